### src/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // One request as it enters the probe engine.
    typedef struct packed {
        logic                opcode;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] record_handle;
    } lpht_req_t;

    // One result as it leaves the probe engine.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] found_handle;
    } lpht_res_t;

endpackage : lpht_pkg
`default_nettype wire

### src/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing, one operation at a time.
// ----------------------------------------------------------------------------
// Usage:
// - Request channel (req_valid/req_ready) carries opcode, key and
//   record_handle. Opcode 0 inserts the key and handle at the first free slot
//   from the home slot (key modulo TABLE_SLOTS); opcode 1 searches for the key.
// - Response channel (rsp_valid/rsp_ready) returns status, slot and
//   found_handle, exactly one response per request, in order.
// - From acceptance to rsp_valid a request passes through hashing in the
//   multiply and correction stages of the home unit, one read issue, then
//   one slot per cycle through the single read port of the slot memory for
//   each of the p slots probed (1 to TABLE_SLOTS), then the hand-over of the
//   result into the output register. The next request is taken in the cycle
//   after the result moves into the output register.
// - After reset the unit sweeps the slot memory to mark every slot empty;
//   req_ready stays low meanwhile.
// - When the receiver stalls, the response waits in the output register and
//   the next request may still be taken; its result waits in the engine until
//   the output register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire logic                             opcode,
    input  wire logic [lpht_pkg::KEY_W-1:0]       key,
    input  wire logic [lpht_pkg::HANDLE_W-1:0]    record_handle,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output logic      [lpht_pkg::STATUS_W-1:0]    status,
    output logic      [lpht_pkg::SLOT_W-1:0]      slot,
    output logic      [lpht_pkg::HANDLE_W-1:0]    found_handle
);
    import lpht_pkg::*;

    lpht_req_t req;
    lpht_res_t res;
    logic      res_valid;
    logic      res_take;
    logic      out_valid_reg;
    logic      out_valid_next;
    lpht_res_t out_reg;
    lpht_res_t out_next;

    assign req = '{opcode: opcode, key: key, record_handle: record_handle};

    lpht_probe_engine #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // Output register: loads when empty or when its content leaves.
    assign res_take = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        priority if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign slot         = out_reg.slot;
    assign found_handle = out_reg.found_handle;

endmodule : linear_probe_hash_table_unit
`default_nettype wire

### src/lpht_home_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_home_unit
// Two-stage home slot calculation: key modulo the slot count by a
// reciprocal multiplication followed by one correcting subtraction.
// ----------------------------------------------------------------------------
module lpht_home_unit #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                              clk,
    input  wire logic [lpht_pkg::KEY_W-1:0]        key,
    output logic      [$clog2(TABLE_SLOTS)-1:0]    home
);
    import lpht_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int SHIFT   = KEY_W + IDX_W;
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam int QN_W    = KEY_W + IDX_W + 1;
    localparam int REM_W   = IDX_W + 1;
    localparam longint unsigned RECIP_L = (64'd1 << SHIFT) / TABLE_SLOTS;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [IDX_W-1:0]  home_reg;
    logic [IDX_W-1:0]  home_next;
    logic [KEY_W-1:0]  quot;
    logic [QN_W-1:0]   quot_n;
    logic [QN_W-1:0]   diff;
    logic [REM_W-1:0]  rem_est;

    // First stage: scaled quotient estimate.
    assign prod_next = PROD_W'(key) * PROD_W'(RECIP);

    // Second stage: remainder from the estimate, at most one slot count too high.
    always_comb
    begin
        quot      = KEY_W'(prod_reg >> SHIFT);
        quot_n    = QN_W'(quot) * QN_W'(TABLE_SLOTS);
        diff      = QN_W'(key) - quot_n;
        rem_est   = diff[REM_W-1:0];
        if (rem_est >= REM_W'(TABLE_SLOTS))
        begin
            home_next = IDX_W'(rem_est - REM_W'(TABLE_SLOTS));
        end
        else
        begin
            home_next = IDX_W'(rem_est);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        home_reg <= home_next;
    end

    assign home = home_reg;

endmodule : lpht_home_unit
`default_nettype wire

### src/lpht_probe_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_probe_engine
// Slot memory and the sequencer that clears it, hashes a request and walks
// the probe sequence one slot per cycle.
// ----------------------------------------------------------------------------
module lpht_probe_engine #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire lpht_pkg::lpht_req_t req,
    output logic                     res_valid,
    input  wire logic                res_take,
    output lpht_pkg::lpht_res_t      res
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_PROBE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } lpht_entry_t;

    lpht_entry_t mem [TABLE_SLOTS];
    lpht_entry_t rd_reg;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    pos_next;
    logic [IDX_W-1:0]    tries_reg;
    logic [IDX_W-1:0]    tries_next;
    logic                op_reg;
    logic                op_next;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    key_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    lpht_res_t           res_reg;
    lpht_res_t           res_next;

    logic [IDX_W-1:0]    home;
    logic [IDX_W-1:0]    pos_inc;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    lpht_entry_t         mem_wdata;
    logic                slot_empty;
    logic                key_match;
    logic                last_try;

    // Home slot of the held key, registered through the product and home registers.
    lpht_home_unit #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_home (
        .clk  (clk),
        .key  (key_reg),
        .home (home)
    );

    // Next slot in probe order, wrapping at the end of the table.
    assign pos_inc    = (pos_reg == LAST_IDX) ? '0 : pos_reg + IDX_W'(1);
    assign slot_empty = !rd_reg.valid;
    assign key_match  = rd_reg.valid && (rd_reg.key == key_reg);
    assign last_try   = (tries_reg == LAST_IDX);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        tries_next  = tries_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        res_next    = res_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = '{valid: 1'b1, key: key_reg, handle: handle_reg};
        rd_addr     = pos_inc;
        unique case (state_reg)
            S_CLEAR:
            begin
                // Clearing pass: one slot per cycle after reset.
                mem_we          = 1'b1;
                mem_wdata.valid = 1'b0;
                if (pos_reg == LAST_IDX)
                begin
                    pos_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    key_next    = req.key;
                    handle_next = req.record_handle;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                // First read at the home slot.
                rd_addr    = home;
                pos_next   = home;
                tries_next = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                // The read of the following slot is issued speculatively.
                if (op_reg == OP_INSERT)
                begin
                    priority if (slot_empty)
                    begin
                        mem_we     = 1'b1;
                        res_next   = '{status: ST_INSERTED, slot: SLOT_W'(pos_reg),
                                       found_handle: '0};
                        state_next = S_DONE;
                    end
                    else if (last_try)
                    begin
                        res_next   = '{status: ST_FULL, slot: '0, found_handle: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        tries_next = tries_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    priority if (slot_empty)
                    begin
                        res_next   = '{status: ST_NOT_FOUND, slot: '0, found_handle: '0};
                        state_next = S_DONE;
                    end
                    else if (key_match)
                    begin
                        res_next   = '{status: ST_FOUND, slot: SLOT_W'(pos_reg),
                                       found_handle: rd_reg.handle};
                        state_next = S_DONE;
                    end
                    else if (last_try)
                    begin
                        res_next   = '{status: ST_NOT_FOUND, slot: '0, found_handle: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        tries_next = tries_reg + IDX_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pos_reg   <= '0;
            tries_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            tries_reg <= tries_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        handle_reg <= handle_next;
        res_reg    <= res_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg] <= mem_wdata;
        end
        rd_reg <= mem[rd_addr];
    end

    assign res = res_reg;

    // A taken request always starts the hash sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_MUL))
        else $error("request taken but hashing did not start");

    // Only an insert writes the table once the clearing pass is over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != S_CLEAR)) |-> (op_reg == OP_INSERT && slot_empty))
        else $error("table written outside an insert into an empty slot");

    // A found result only comes from a search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_FOUND) |-> (op_reg == OP_SEARCH))
        else $error("found status reported for an insert");

    // An insert never reports a search status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && op_reg == OP_INSERT) |->
            (res.status == ST_INSERTED || res.status == ST_FULL))
        else $error("insert result carries a search status");

endmodule : lpht_probe_engine
`default_nettype wire

### tb/linear_probe_hash_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit_test
// Self-checking bench for the linear probing hash table unit. A shadow copy
// of the table predicts the status, slot and handle of every request. The
// table is filled gradually, so searches meet clusters, wraparound and empty
// stops before the table finally fills and the full-table cases take over.
// Both channels idle at random, with one long response hold-off and two
// drains of all outstanding requests.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit_test;

    import lpht_pkg::*;

    localparam int SLOTS         = 16;
    localparam int RANDOM_ITEMS  = 940;
    localparam int FILL_AFTER    = 600;
    localparam int DRAIN_AT      = 450;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 5000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    logic                opcode;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] record_handle;
    logic                rsp_valid;
    logic                rsp_ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] found_handle;

    // Keys handed to insert requests so far, duplicates included.
    logic [KEY_W-1:0]    inserted_keys [$];
    int                  responses = 0;

    // Shadow copy of the table and the results still owed by the unit.
    class lpht_shadow_table;
        bit                  valid_mark    [SLOTS];
        logic [KEY_W-1:0]    stored_key    [SLOTS];
        logic [HANDLE_W-1:0] stored_handle [SLOTS];
        lpht_res_t           owed_results  [$];
        int                  occupied   = 0;
        int                  mismatches = 0;

        // Probe the shadow table for one accepted request and queue its result.
        function void note_request(logic op, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
            lpht_res_t want;
            int        pos;
            bit        done;
            want        = '0;
            want.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            pos         = int'(k) % SLOTS;
            done        = 1'b0;
            for (int tries = 0; tries < SLOTS && !done; tries++)
            begin
                if (!valid_mark[pos])
                begin
                    // An empty slot takes an insert and ends a search.
                    if (op == OP_INSERT)
                    begin
                        valid_mark[pos]    = 1'b1;
                        stored_key[pos]    = k;
                        stored_handle[pos] = h;
                        occupied++;
                        want.status = ST_INSERTED;
                        want.slot   = SLOT_W'(pos);
                    end
                    done = 1'b1;
                end
                else if (op == OP_SEARCH && stored_key[pos] == k)
                begin
                    want.status       = ST_FOUND;
                    want.slot         = SLOT_W'(pos);
                    want.found_handle = stored_handle[pos];
                    done              = 1'b1;
                end
                pos = (pos + 1) % SLOTS;
            end
            owed_results.push_back(want);
        endfunction

        // Compare one accepted response with the oldest owed result.
        function void check_response(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                                     logic [HANDLE_W-1:0] fh);
            lpht_res_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: response with none owed: status %0d slot %0d handle %h",
                         $time, st, sl, fh);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, st);
                mismatches++;
            end
            if (sl !== want.slot)
            begin
                $display("%0t: slot expected %0d, got %0d", $time, want.slot, sl);
                mismatches++;
            end
            if (fh !== want.found_handle)
            begin
                $display("%0t: found_handle expected %h, got %h", $time, want.found_handle, fh);
                mismatches++;
            end
        endfunction
    endclass

    lpht_shadow_table board = new();

    linear_probe_hash_table_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .key           (key),
        .record_handle (record_handle),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .slot          (slot),
        .found_handle  (found_handle)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // New key whose home slot leans toward the wrap point of the table.
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [SLOT_W-1:0] home;
        if ($urandom_range(0, 1) == 0)
            home = SLOT_W'($urandom_range(0, 3)) - 4'd2;
        else
            home = SLOT_W'($urandom());
        return {12'($urandom()), home};
    endfunction

    function automatic logic [KEY_W-1:0] insert_key();
        if (inserted_keys.size() != 0 && $urandom_range(0, 9) < 2)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        return fresh_key();
    endfunction

    // Search keys: stored keys, misses inside a stored key's cluster, or anything.
    function automatic logic [KEY_W-1:0] search_key();
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(0, 9);
        if (inserted_keys.size() == 0 || r >= 8)
            return KEY_W'($urandom());
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        if (r < 5)
            return k;
        return {12'($urandom()), k[SLOT_W-1:0]};
    endfunction

    // Offer one request, hold it until accepted, then idle for a random gap, possibly none.
    // With drain set, valid drops and the sender waits for every result.
    task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                                input logic [HANDLE_W-1:0] h, input bit calm,
                                input bit drain);
        int gap;
        req_valid     <= 1'b1;
        opcode        <= op;
        key           <= k;
        record_handle <= h;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_request(op, k, h);
        if (op == OP_INSERT)
            inserted_keys.push_back(k);
        gap = pick_gap(calm);
        if (drain && gap == 0)
            gap = 1;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (drain)
        begin
            while (board.owed_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Request side: reset, directed cases, then the random fill of the table.
    initial
    begin : request_side
        logic op;
        bit   calm;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        opcode        = OP_INSERT;
        key           = '0;
        record_handle = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, wraparound at the top slot, duplicates and extremes.
        send_request(OP_SEARCH, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
        send_request(OP_INSERT, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_request(OP_INSERT, 16'h000F, 16'hFFFF, 1'b0, 1'b0);
        send_request(OP_INSERT, 16'h001F, 16'h1234, 1'b0, 1'b0);
        send_request(OP_INSERT, 16'hFFFF, 16'hABCD, 1'b0, 1'b0);
        send_request(OP_SEARCH, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_request(OP_SEARCH, 16'h001F, 16'h5A5A, 1'b0, 1'b0);
        send_request(OP_SEARCH, 16'h002F, 16'h0000, 1'b0, 1'b0);
        send_request(OP_INSERT, 16'h0000, 16'h5555, 1'b0, 1'b0);
        send_request(OP_SEARCH, 16'h0000, 16'hAAAA, 1'b0, 1'b0);
        send_request(OP_SEARCH, 16'h8000, 16'hFFFF, 1'b0, 1'b0);
        send_request(OP_INSERT, 16'h7FF8, 16'h8000, 1'b0, 1'b0);
        send_request(OP_SEARCH, 16'h7FF8, 16'h7FFF, 1'b0, 1'b0);
        send_request(OP_SEARCH, 16'h7FF0, 16'h0001, 1'b0, 1'b0);

        // Mostly searches; inserts are rare until late, when the table is
        // pushed to full so that full inserts and full-table misses follow.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n % 200) < 40;
            if (board.occupied == SLOTS)
                op = ($urandom_range(0, 5) == 0) ? OP_INSERT : OP_SEARCH;
            else if (n > FILL_AFTER)
                op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_SEARCH;
            else
                op = ($urandom_range(0, 49) == 0) ? OP_INSERT : OP_SEARCH;
            send_request(op, (op == OP_INSERT) ? insert_key() : search_key(),
                         HANDLE_W'($urandom()), calm,
                         n == DRAIN_AT || n == RANDOM_ITEMS - 1);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.owed_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Response side: check each accepted response and stall at random, with
    // one long hold-off so that the unit backs up and stops taking requests.
    initial
    begin : response_side
        int stall_left;
        stall_left = 0;
        rsp_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                board.check_response(status, slot, found_handle);
                responses++;
                if (responses == HOLD_AT)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && (responses % 250) >= 50 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap(1'b0);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a handshake on either channel ends the run.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule
